/* design/rmma_pkg.sv */
package rmma_pkg;

   localparam int COEF_WIDTH     = 62;
   localparam int HINT_WIDTH     = 64;
   localparam int INDEX_WIDTH    = 2;
   localparam int REG_COUNT      = 4;
   localparam int REG_INDEX_WIDTH = 2;
   localparam int CSR_ADDR_WIDTH = 5;
   localparam int CSR_DATA_WIDTH = 64;
   localparam int CSR_INDEX_LSB  = 3;
   // acc + factor*term stays below 2^125
   localparam int DIVIDEND_WIDTH = 2 * COEF_WIDTH + 1;
   localparam int HALF           = 32;

   typedef logic [COEF_WIDTH-1:0]      coef_type;
   typedef logic [HINT_WIDTH-1:0]      hint_type;
   typedef logic [INDEX_WIDTH-1:0]     modulus_index_type;
   typedef logic [REG_INDEX_WIDTH-1:0] reg_index_type;
   typedef logic [CSR_ADDR_WIDTH-1:0]  csr_addr_type;
   typedef logic [CSR_DATA_WIDTH-1:0]  csr_data_type;
   typedef logic [DIVIDEND_WIDTH-1:0]  dividend_type;

   localparam coef_type MODULUS_RESET = COEF_WIDTH'(2);

   typedef enum logic {
      MODE_PLAIN = 1'b0,
      MODE_SHOUP = 1'b1
   } mode_type;

   // fields carried alongside the front-end arithmetic
   typedef struct packed {
      mode_type mode;
      coef_type acc;
      coef_type modulus;
   } front_ctl_type;

   // one slot of the restoring reduction chain
   typedef struct packed {
      logic         bypass;
      coef_type     modulus;
      coef_type     rem;
      dividend_type dividend;
   } red_stage_type;

endpackage

/* design/rmma_req_if.sv */
interface rmma_req_if;
   import rmma_pkg::*;

   logic              valid;
   logic              ready;
   mode_type          mode;
   modulus_index_type modulus_index;
   coef_type          accumulator_in;
   coef_type          factor_value;
   coef_type          term_value;
   hint_type          term_hint;

   modport source (
      output valid, mode, modulus_index, accumulator_in, factor_value, term_value, term_hint,
      input  ready
   );

   modport sink (
      input  valid, mode, modulus_index, accumulator_in, factor_value, term_value, term_hint,
      output ready
   );

endinterface

/* design/rmma_rsp_if.sv */
interface rmma_rsp_if;
   import rmma_pkg::*;

   logic     valid;
   logic     ready;
   coef_type accumulator_out;

   modport source (
      output valid, accumulator_out,
      input  ready
   );

   modport sink (
      input  valid, accumulator_out,
      output ready
   );

endinterface

/* design/rmma_reduce_chain.sv */
module rmma_reduce_chain (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    advance,
   input  logic                    entry_valid,
   input  rmma_pkg::red_stage_type entry,
   output logic                    result_valid,
   output rmma_pkg::coef_type      result
);
   import rmma_pkg::*;

   localparam int STEPS = DIVIDEND_WIDTH;

   logic          valid_ff [STEPS];
   logic          valid_in [STEPS];
   red_stage_type stage_ff [STEPS];
   red_stage_type stage_in [STEPS];

   // one shift-subtract step; bypassed items keep their remainder
   function automatic red_stage_type div_step(input red_stage_type cur);
      red_stage_type         nxt;
      logic [COEF_WIDTH:0]   trial;
      logic [COEF_WIDTH+1:0] diff;
      nxt          = cur;
      trial        = {cur.rem, cur.dividend[DIVIDEND_WIDTH-1]};
      diff         = {1'b0, trial} - {2'b00, cur.modulus};
      nxt.dividend = {cur.dividend[DIVIDEND_WIDTH-2:0], 1'b0};
      if (!cur.bypass) begin
         if (!diff[COEF_WIDTH+1]) begin
            nxt.rem = diff[COEF_WIDTH-1:0];
         end else begin
            nxt.rem = trial[COEF_WIDTH-1:0];
         end
      end
      return nxt;
   endfunction

   for (genvar g = 0; g < STEPS; g++) begin : g_step
      if (g == 0) begin : g_first
         assign stage_in[g] = div_step(entry);
         assign valid_in[g] = entry_valid;
      end else begin : g_rest
         assign stage_in[g] = div_step(stage_ff[g-1]);
         assign valid_in[g] = valid_ff[g-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < STEPS; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else if (advance) begin
         for (int i = 0; i < STEPS; i++) begin
            valid_ff[i] <= valid_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i < STEPS; i++) begin
            stage_ff[i] <= stage_in[i];
         end
      end
   end

   assign result_valid = valid_ff[STEPS-1];
   assign result       = stage_ff[STEPS-1].rem;

endmodule

/* design/rns_modular_multiply_accumulate.sv */
// Path: input transfer -> front end -> reduction chain -> skid queue -> rsp.
// Throughput: one item per cycle while the skid queue has room; each of the 125
//   reduction stages does one restoring trial subtraction; the whole pipeline moves as one.
// Output side: two-entry skid queue; the pipeline halts only while both entries are full.
// Reset (synchronous, active high): clears all valid bits and the skid queue and sets
//   every modulus register to 2; no clearing pass.
module rns_modular_multiply_accumulate #(
   parameter int MODULUS_COUNT = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   rmma_req_if.sink               req_channel,
   rmma_rsp_if.source             rsp_channel,
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  rmma_pkg::csr_addr_type csr_paddr,
   input  rmma_pkg::csr_data_type csr_pwdata,
   output rmma_pkg::csr_data_type csr_prdata,
   output logic                   csr_pready
);
   import rmma_pkg::*;

   localparam int FRONT_STAGES  = 9;              // stages ahead of the reduction chain
   localparam int CTL_STAGES    = 8;              // mode/acc/modulus ride along stages 1..8
   localparam int N_STAGES      = 5;              // full sum lives in stages 4..8
   localparam int PRODUCT_WIDTH = 2 * HALF;
   localparam int MID_WIDTH     = 2 * HALF + 1;
   localparam int WIDE_WIDTH    = 4 * HALF;
   localparam int PROD_WIDTH    = 2 * COEF_WIDTH;
   localparam int SKID_DEPTH    = 2;
   localparam int SKID_PTR_WIDTH = 1;
   localparam logic [1:0] SKID_FULL = 2'(SKID_DEPTH);

   // index beyond the modulus count wraps around; narrow value, so repeated subtraction
   function automatic reg_index_type map_index(input modulus_index_type idx);
      logic [3:0] m;
      m = {2'b00, idx};
      for (int i = 0; i < 3; i++) begin
         if (m >= 4'(MODULUS_COUNT)) begin
            m = m - 4'(MODULUS_COUNT);
         end
      end
      return m[REG_INDEX_WIDTH-1:0];
   endfunction

   // ---------------------------------------------------------------
   // Configuration registers: modulus i at byte address 8*i
   // ---------------------------------------------------------------
   coef_type      modulus_ff [REG_COUNT];
   logic          csr_write;
   reg_index_type csr_index;

   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[CSR_ADDR_WIDTH-1:CSR_INDEX_LSB];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = {{(CSR_DATA_WIDTH-COEF_WIDTH){1'b0}}, modulus_ff[csr_index]};

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < REG_COUNT; i++) begin
            modulus_ff[i] <= MODULUS_RESET;
         end
      end else if (csr_write) begin
         modulus_ff[csr_index] <= csr_pwdata[COEF_WIDTH-1:0];
      end
   end

   // ---------------------------------------------------------------
   // Global advance: every stage moves together while the skid queue
   // has room. Ready does not look at rsp ready combinationally.
   // ---------------------------------------------------------------
   logic        advance;
   logic [1:0]  skid_count_ff;

   assign advance           = (skid_count_ff != SKID_FULL);
   assign req_channel.ready = advance;

   // ---------------------------------------------------------------
   // Front end registers
   // ---------------------------------------------------------------
   logic          front_valid_ff [FRONT_STAGES];
   front_ctl_type ctl_ff [CTL_STAGES];
   front_ctl_type ctl_in;

   // stage 1: 32x32 partial products of factor*term and factor*hint
   // index 0 lo*lo, 1 lo*hi, 2 hi*lo, 3 hi*hi
   logic [PRODUCT_WIDTH-1:0] s1_ab_ff [4];
   logic [PRODUCT_WIDTH-1:0] s1_ah_ff [4];
   logic [PRODUCT_WIDTH-1:0] s1_ab_in [4];
   logic [PRODUCT_WIDTH-1:0] s1_ah_in [4];
   logic [HALF-1:0]          a_lo, a_hi, b_lo, b_hi, h_lo, h_hi;

   // stage 2: cross terms summed
   logic [WIDE_WIDTH-1:0] s2_ab_outer_ff, s2_ah_outer_ff;
   logic [MID_WIDTH-1:0]  s2_ab_mid_ff, s2_ah_mid_ff;
   logic [MID_WIDTH-1:0]  s2_ab_mid_in, s2_ah_mid_in;

   // stage 3: full factor*term and the Shoup quotient estimate
   logic [WIDE_WIDTH-1:0] ab_sum, ah_sum;
   logic [PROD_WIDTH-1:0] s3_prod_ff;
   hint_type              s3_qh_ff;

   // stage 4: plain sum acc + product; q_hat*q partial products
   dividend_type          n_ff [N_STAGES];
   dividend_type          s4_n_in;
   logic [PRODUCT_WIDTH-1:0] s4_ftlo_ff, s4_x00_ff, s4_x00_in;
   logic [HALF-1:0]       s4_x01_ff, s4_x10_ff;
   logic [PRODUCT_WIDTH-1:0] x01_full, x10_full;

   // stages 5..8: Shoup remainder and the two conditional subtractions
   logic [HALF-1:0]          s5_cross_ff;
   logic [PRODUCT_WIDTH-1:0] s5_diff_ff, s6_r_ff, s7_r_ff, s8_s_ff;
   logic [PRODUCT_WIDTH-1:0] s7_r_in, s8_s_in;
   logic [PRODUCT_WIDTH-1:0] q6_wide, q8_wide, s9_s_fixed;

   // stage 9: reduction chain entry
   red_stage_type s9_entry_ff, s9_entry_in;

   assign a_lo = req_channel.factor_value[HALF-1:0];
   assign a_hi = HALF'(req_channel.factor_value[COEF_WIDTH-1:HALF]);
   assign b_lo = req_channel.term_value[HALF-1:0];
   assign b_hi = HALF'(req_channel.term_value[COEF_WIDTH-1:HALF]);
   assign h_lo = req_channel.term_hint[HALF-1:0];
   assign h_hi = req_channel.term_hint[HINT_WIDTH-1:HALF];

   always_comb begin
      ctl_in.mode    = req_channel.mode;
      ctl_in.acc     = req_channel.accumulator_in;
      ctl_in.modulus = modulus_ff[map_index(req_channel.modulus_index)];

      s1_ab_in[0] = a_lo * b_lo;
      s1_ab_in[1] = a_lo * b_hi;
      s1_ab_in[2] = a_hi * b_lo;
      s1_ab_in[3] = a_hi * b_hi;
      s1_ah_in[0] = a_lo * h_lo;
      s1_ah_in[1] = a_lo * h_hi;
      s1_ah_in[2] = a_hi * h_lo;
      s1_ah_in[3] = a_hi * h_hi;

      s2_ab_mid_in = {1'b0, s1_ab_ff[1]} + {1'b0, s1_ab_ff[2]};
      s2_ah_mid_in = {1'b0, s1_ah_ff[1]} + {1'b0, s1_ah_ff[2]};

      ab_sum = s2_ab_outer_ff
             + {{(WIDE_WIDTH-MID_WIDTH-HALF){1'b0}}, s2_ab_mid_ff, {HALF{1'b0}}};
      ah_sum = s2_ah_outer_ff
             + {{(WIDE_WIDTH-MID_WIDTH-HALF){1'b0}}, s2_ah_mid_ff, {HALF{1'b0}}};

      // ctl_ff[2] is stage 3
      s4_n_in   = {1'b0, s3_prod_ff} + {{(DIVIDEND_WIDTH-COEF_WIDTH){1'b0}}, ctl_ff[2].acc};
      s4_x00_in = s3_qh_ff[HALF-1:0] * ctl_ff[2].modulus[HALF-1:0];
      x01_full  = s3_qh_ff[HALF-1:0] * HALF'(ctl_ff[2].modulus[COEF_WIDTH-1:HALF]);
      x10_full  = s3_qh_ff[HINT_WIDTH-1:HALF] * ctl_ff[2].modulus[HALF-1:0];

      // first conditional subtraction, stage 6 inputs
      q6_wide = {{(PRODUCT_WIDTH-COEF_WIDTH){1'b0}}, ctl_ff[5].modulus};
      s7_r_in = (s6_r_ff >= q6_wide) ? (s6_r_ff - q6_wide) : s6_r_ff;

      // wrap-around accumulate, stage 7 inputs
      s8_s_in = {{(PRODUCT_WIDTH-COEF_WIDTH){1'b0}}, ctl_ff[6].acc} + s7_r_ff;

      // second conditional subtraction and chain entry, stage 8 inputs
      q8_wide    = {{(PRODUCT_WIDTH-COEF_WIDTH){1'b0}}, ctl_ff[7].modulus};
      s9_s_fixed = (s8_s_ff >= q8_wide) ? (s8_s_ff - q8_wide) : s8_s_ff;

      // Shoup items and a zero modulus in plain mode skip the reduction steps
      s9_entry_in.bypass   = (ctl_ff[7].mode == MODE_SHOUP) || (ctl_ff[7].modulus == '0);
      s9_entry_in.modulus  = ctl_ff[7].modulus;
      s9_entry_in.rem      = (ctl_ff[7].mode == MODE_SHOUP) ? s9_s_fixed[COEF_WIDTH-1:0] : '0;
      s9_entry_in.dividend = n_ff[N_STAGES-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < FRONT_STAGES; k++) begin
            front_valid_ff[k] <= 1'b0;
         end
      end else if (advance) begin
         front_valid_ff[0] <= req_channel.valid;
         for (int k = 1; k < FRONT_STAGES; k++) begin
            front_valid_ff[k] <= front_valid_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         ctl_ff[0] <= ctl_in;
         for (int k = 1; k < CTL_STAGES; k++) begin
            ctl_ff[k] <= ctl_ff[k-1];
         end

         for (int i = 0; i < 4; i++) begin
            s1_ab_ff[i] <= s1_ab_in[i];
            s1_ah_ff[i] <= s1_ah_in[i];
         end

         s2_ab_outer_ff <= {s1_ab_ff[3], s1_ab_ff[0]};
         s2_ah_outer_ff <= {s1_ah_ff[3], s1_ah_ff[0]};
         s2_ab_mid_ff   <= s2_ab_mid_in;
         s2_ah_mid_ff   <= s2_ah_mid_in;

         s3_prod_ff <= ab_sum[PROD_WIDTH-1:0];
         s3_qh_ff   <= ah_sum[WIDE_WIDTH-1:WIDE_WIDTH-HINT_WIDTH];

         n_ff[0] <= s4_n_in;
         for (int k = 1; k < N_STAGES; k++) begin
            n_ff[k] <= n_ff[k-1];
         end
         s4_ftlo_ff <= s3_prod_ff[PRODUCT_WIDTH-1:0];
         s4_x00_ff  <= s4_x00_in;
         s4_x01_ff  <= x01_full[HALF-1:0];
         s4_x10_ff  <= x10_full[HALF-1:0];

         s5_cross_ff <= s4_x01_ff + s4_x10_ff;
         s5_diff_ff  <= s4_ftlo_ff - s4_x00_ff;

         // r = factor*term - q_hat*q, mod 2^64
         s6_r_ff <= s5_diff_ff - {s5_cross_ff, {HALF{1'b0}}};
         s7_r_ff <= s7_r_in;
         s8_s_ff <= s8_s_in;

         s9_entry_ff <= s9_entry_in;
      end
   end

   // ---------------------------------------------------------------
   // Restoring reduction of the plain sum, one bit per stage
   // ---------------------------------------------------------------
   logic     chain_valid;
   coef_type chain_rem;

   rmma_reduce_chain u_reduce_chain (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .entry_valid  (front_valid_ff[FRONT_STAGES-1]),
      .entry        (s9_entry_ff),
      .result_valid (chain_valid),
      .result       (chain_rem)
   );

   // ---------------------------------------------------------------
   // Output skid queue
   // ---------------------------------------------------------------
   coef_type                  skid_ff [SKID_DEPTH];
   logic [SKID_PTR_WIDTH-1:0] skid_wr_ptr_ff, skid_rd_ptr_ff;
   logic                      skid_push, skid_pop;

   assign skid_push = advance && chain_valid;
   assign skid_pop  = rsp_channel.valid && rsp_channel.ready;

   assign rsp_channel.valid           = (skid_count_ff != '0);
   assign rsp_channel.accumulator_out = skid_ff[skid_rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         skid_count_ff  <= '0;
         skid_wr_ptr_ff <= '0;
         skid_rd_ptr_ff <= '0;
      end else begin
         if (skid_push) begin
            skid_wr_ptr_ff <= skid_wr_ptr_ff + 1'b1;
         end
         if (skid_pop) begin
            skid_rd_ptr_ff <= skid_rd_ptr_ff + 1'b1;
         end
         unique case ({skid_push, skid_pop})
            2'b10:   skid_count_ff <= skid_count_ff + 2'd1;
            2'b01:   skid_count_ff <= skid_count_ff - 2'd1;
            default: skid_count_ff <= skid_count_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (skid_push) begin
         skid_ff[skid_wr_ptr_ff] <= chain_rem;
      end
   end

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps

module testbench;
   import rmma_pkg::*;

   localparam int MODULUS_COUNT = 4;

   // random part: three idle profiles, one block of items each
   localparam int ITEMS_PER_PHASE = 600;
   // in the last phase the sender stops here until everything is back
   localparam int SENDER_PAUSE_AT = 400;
   // long receiver hold-off, placed inside the last (no idling) phase
   localparam int HOLD_AFTER_INPUTS = 1250;
   localparam int HOLD_CYCLES = 400;
   // pipeline is 134 deep; settle a little past that at the end
   localparam int END_SETTLE = 200;
   // cycles with no transfer anywhere before the run is called hung
   localparam int QUIET_LIMIT = 3000;
   localparam int REPORT_LIMIT = 10;

   localparam coef_type COEF_MAX = {COEF_WIDTH{1'b1}};
   // 2^62 - 57, the largest prime below 2^62
   localparam coef_type LARGE_PRIME = 62'h3FFF_FFFF_FFFF_FFC7;

   typedef struct {
      mode_type          mode;
      modulus_index_type mod_sel;
      coef_type          acc;
      coef_type          fac;
      coef_type          trm;
      hint_type          hint;
   } coef_item;

   logic         clock;
   logic         reset;
   logic         csr_psel;
   logic         csr_penable;
   logic         csr_pwrite;
   csr_addr_type csr_paddr;
   csr_data_type csr_pwdata;
   csr_data_type csr_prdata;
   logic         csr_pready;

   rmma_req_if req_bus ();
   rmma_rsp_if rsp_bus ();

   rns_modular_multiply_accumulate #(
      .MODULUS_COUNT (MODULUS_COUNT)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .req_channel (req_bus),
      .rsp_channel (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // shadow of the modulus registers, updated as each write lands
   coef_type    modulus_table [REG_COUNT];
   coef_item    waiting_items [$];
   coef_type    expected_accumulators [$];

   int unsigned items_issued;
   int unsigned inputs_accepted;
   int unsigned results_seen;
   int unsigned mismatch_count;
   int unsigned sender_idle_pct;
   int unsigned receiver_idle_pct;
   int unsigned hold_left;
   int unsigned quiet_cycles;
   logic        hold_done;
   logic        req_taken;

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   function automatic void log_failure(string msg);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT) begin
         $display("%s", msg);
      end
   endfunction

   // floor(term * 2^64 / q), the Shoup precomputation for a given term
   function automatic hint_type shoup_hint(coef_type trm, coef_type q);
      return hint_type'({64'(trm), 64'b0} / 128'(q));
   endfunction

   // New accumulator value for one transfer, against the shadow moduli.
   // Plain mode reduces the exact 125-bit sum; Shoup mode wraps mod 2^64
   // and does each conditional subtract once, so bad hints or unreduced
   // operands may leave the result unreduced.
   function automatic coef_type predict_accumulator(coef_item it);
      logic [127:0] wide;
      logic [63:0]  q;
      logic [63:0]  q_hat;
      logic [63:0]  r;
      logic [63:0]  s;
      q = 64'(modulus_table[it.mod_sel % MODULUS_COUNT]);
      if (it.mode == MODE_PLAIN) begin
         if (q == 64'd0) begin
            return '0;
         end
         wide = 128'(it.fac) * 128'(it.trm) + 128'(it.acc);
         return coef_type'(wide % 128'(q));
      end
      wide = 128'(it.fac) * 128'(it.hint);
      q_hat = wide[127:64];
      r = 64'(it.fac) * 64'(it.trm) - q_hat * q;
      if (r >= q) begin
         r = r - q;
      end
      s = 64'(it.acc) + r;
      if (s >= q) begin
         s = s - q;
      end
      return coef_type'(s);
   endfunction

   function automatic coef_type random_coef();
      return coef_type'({$urandom, $urandom});
   endfunction

   function automatic coef_type random_below(coef_type q);
      if (q == '0) begin
         return random_coef();
      end
      return coef_type'({$urandom, $urandom} % 64'(q));
   endfunction

   function automatic coef_type extreme_coef();
      case ($urandom_range(2))
         0: return '0;
         1: return COEF_MAX;
         default: return random_coef();
      endcase
   endfunction

   // mostly wide odd moduli, sometimes tiny or all ones
   function automatic coef_type pick_modulus();
      case ($urandom_range(9))
         0: return coef_type'($urandom_range(1000, 3) | 1);
         1: return COEF_MAX;
         default: return {1'b1, 29'($urandom), $urandom} | coef_type'(1);
      endcase
   endfunction

   // 80% well formed (reduced operands, true hint), the rest noise
   function automatic coef_item random_item();
      coef_item    it;
      coef_type    q;
      int unsigned kind;
      it.mode = mode_type'($urandom_range(1));
      it.mod_sel = modulus_index_type'($urandom_range(REG_COUNT - 1));
      q = modulus_table[it.mod_sel % MODULUS_COUNT];
      kind = $urandom_range(99);
      if (kind < 80) begin
         it.acc = random_below(q);
         it.fac = random_below(q);
         it.trm = random_below(q);
         if (it.mode == MODE_SHOUP && q != '0) begin
            it.hint = shoup_hint(it.trm, q);
         end else begin
            it.hint = {$urandom, $urandom};
         end
      end else if (kind < 90) begin
         it.acc = random_coef();
         it.fac = random_coef();
         it.trm = random_coef();
         it.hint = {$urandom, $urandom};
      end else begin
         it.acc = extreme_coef();
         it.fac = extreme_coef();
         it.trm = extreme_coef();
         it.hint = $urandom_range(1) ? '1 : '0;
      end
      return it;
   endfunction

   task automatic queue_item(coef_item it);
      waiting_items.push_back(it);
      items_issued++;
   endtask

   task automatic queue_directed(mode_type mode, int unsigned sel, coef_type acc,
                                 coef_type fac, coef_type trm, hint_type hint);
      coef_item it;
      it.mode = mode;
      it.mod_sel = modulus_index_type'(sel);
      it.acc = acc;
      it.fac = fac;
      it.trm = trm;
      it.hint = hint;
      queue_item(it);
   endtask

   task automatic wait_for_results();
      while (results_seen != items_issued) begin
         @(posedge clock);
      end
   endtask

   task automatic csr_read_check(int unsigned idx);
      csr_data_type want;
      want = csr_data_type'(modulus_table[idx]);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= csr_addr_type'(idx << CSR_INDEX_LSB);
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== want) begin
         log_failure($sformatf("mismatch: modulus_%0d readback expected %h got %h",
                               idx, want, csr_prdata));
      end
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // write one modulus (junk in the two bits above the field), then read it back
   task automatic set_modulus(int unsigned idx, coef_type value);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= csr_addr_type'(idx << CSR_INDEX_LSB);
      csr_pwdata <= {2'($urandom), value};
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      modulus_table[idx] = value;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_read_check(idx);
   endtask

   // Request driver: a new item goes out only when the bus is empty or the
   // last one transferred at the previous rising edge.
   always @(negedge clock) begin : request_driver
      coef_item it;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_bus.valid || req_taken) begin
         if (waiting_items.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
            it = waiting_items.pop_front();
            req_bus.valid <= 1'b1;
            req_bus.mode <= it.mode;
            req_bus.modulus_index <= it.mod_sel;
            req_bus.accumulator_in <= it.acc;
            req_bus.factor_value <= it.fac;
            req_bus.term_value <= it.trm;
            req_bus.term_hint <= it.hint;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // Result ready: random back-pressure, plus one long hold-off once enough
   // inputs went in, so the pipeline fills and stalls the request side.
   always @(negedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_bus.ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (!hold_done && inputs_accepted >= HOLD_AFTER_INPUTS) begin
         rsp_bus.ready <= 1'b0;
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= receiver_idle_pct);
      end
   end

   // Monitor: check results first, then record what each accepted request
   // should produce. Counters move on nonblocking updates so readers in
   // other processes see a stable value at the edge.
   always @(posedge clock) begin : transfer_monitor
      coef_type want;
      coef_item it;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_bus.valid && req_bus.ready;
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_accumulators.size() == 0) begin
               log_failure($sformatf("mismatch: unexpected result %h",
                                     rsp_bus.accumulator_out));
            end else begin
               want = expected_accumulators.pop_front();
               if (rsp_bus.accumulator_out !== want) begin
                  log_failure($sformatf(
                     "mismatch: result %0d accumulator_out expected %h got %h",
                     results_seen, want, rsp_bus.accumulator_out));
               end
            end
            results_seen <= results_seen + 1;
         end
         if (req_bus.valid && req_bus.ready) begin
            it.mode = req_bus.mode;
            it.mod_sel = req_bus.modulus_index;
            it.acc = req_bus.accumulator_in;
            it.fac = req_bus.factor_value;
            it.trm = req_bus.term_value;
            it.hint = req_bus.term_hint;
            expected_accumulators.push_back(predict_accumulator(it));
            inputs_accepted <= inputs_accepted + 1;
         end
      end
   end

   // hang detection: any transfer on either channel or the CSR port resets it
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
          || csr_psel) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   initial begin : stimulus
      int unsigned phase;
      int unsigned n;
      reset = 1'b1;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      req_bus.valid = 1'b0;
      req_bus.mode = MODE_PLAIN;
      req_bus.modulus_index = '0;
      req_bus.accumulator_in = '0;
      req_bus.factor_value = '0;
      req_bus.term_value = '0;
      req_bus.term_hint = '0;
      rsp_bus.ready = 1'b0;
      items_issued = 0;
      inputs_accepted = 0;
      results_seen = 0;
      mismatch_count = 0;
      hold_left = 0;
      hold_done = 1'b0;
      quiet_cycles = 0;
      sender_idle_pct = 31;
      receiver_idle_pct = 81;
      for (int i = 0; i < REG_COUNT; i++) begin
         modulus_table[i] = MODULUS_RESET;
      end

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset values must read back before anything is written
      for (int i = 0; i < REG_COUNT; i++) begin
         csr_read_check(i);
      end

      // a couple of transfers against the reset moduli
      queue_directed(MODE_PLAIN, 0, 1, 1, 1, '0);
      queue_directed(MODE_SHOUP, 3, 1, 1, 1, shoup_hint(1, MODULUS_RESET));
      wait_for_results();

      // directed corners: zero, one, all-ones and a large prime modulus
      set_modulus(0, '0);
      set_modulus(1, coef_type'(1));
      set_modulus(2, COEF_MAX);
      set_modulus(3, LARGE_PRIME);

      // zero modulus: plain gives 0, Shoup just runs the steps
      queue_directed(MODE_PLAIN, 0, COEF_MAX, COEF_MAX, COEF_MAX, '1);
      queue_directed(MODE_SHOUP, 0, COEF_MAX, COEF_MAX, COEF_MAX, '1);
      queue_directed(MODE_SHOUP, 0, '0, '0, '0, '0);
      // modulus of one
      queue_directed(MODE_PLAIN, 1, 5, 7, 9, '0);
      queue_directed(MODE_SHOUP, 1, '0, '0, '0, '0);
      queue_directed(MODE_SHOUP, 1, COEF_MAX, 5, 7, '1);
      // all-ones modulus, unreduced accumulator in plain mode
      queue_directed(MODE_PLAIN, 2, COEF_MAX, COEF_MAX, COEF_MAX, '0);
      queue_directed(MODE_PLAIN, 2, '0, '0, '0, '1);
      queue_directed(MODE_SHOUP, 2, COEF_MAX - 1, COEF_MAX - 1, COEF_MAX - 1,
                     shoup_hint(COEF_MAX - 1, COEF_MAX));
      // wrong (zero) hint
      queue_directed(MODE_SHOUP, 2, 1, COEF_MAX - 1, 1, '0);
      // large prime: largest reduced operands, true and bogus hints
      queue_directed(MODE_PLAIN, 3, LARGE_PRIME - 1, LARGE_PRIME - 1, LARGE_PRIME - 1, '0);
      queue_directed(MODE_SHOUP, 3, LARGE_PRIME - 1, LARGE_PRIME - 1, LARGE_PRIME - 1,
                     shoup_hint(LARGE_PRIME - 1, LARGE_PRIME));
      queue_directed(MODE_SHOUP, 3, '0, '0, '0, '0);
      queue_directed(MODE_SHOUP, 3, LARGE_PRIME - 1, LARGE_PRIME - 1, LARGE_PRIME - 1, '1);
      // unreduced operands in Shoup mode wrap and may stay unreduced
      queue_directed(MODE_SHOUP, 3, COEF_MAX, COEF_MAX, COEF_MAX, '1);
      queue_directed(MODE_PLAIN, 3, COEF_MAX, '0, '0, '0);
      wait_for_results();

      // random phases: receiver-heavy idling, sender-heavy idling, then none
      for (phase = 0; phase < 3; phase++) begin
         sender_idle_pct = (phase == 0) ? 31 : (phase == 1) ? 81 : 0;
         receiver_idle_pct = (phase == 0) ? 81 : (phase == 1) ? 31 : 0;
         for (int i = 0; i < REG_COUNT; i++) begin
            set_modulus(i, pick_modulus());
         end
         for (n = 0; n < ITEMS_PER_PHASE; n++) begin
            // sender stalls until the pipeline has fully drained
            if (phase == 2 && n == SENDER_PAUSE_AT) begin
               wait_for_results();
            end
            queue_item(random_item());
         end
         wait_for_results();
      end

      repeat (END_SETTLE) @(posedge clock);
      if (expected_accumulators.size() != 0) begin
         log_failure($sformatf("mismatch: %0d results never arrived",
                               expected_accumulators.size()));
      end
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
